// File: hdl/mts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mts_pkg
// shared command codes and their width for the min-tracking stack
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam int CMD_WIDTH = 2;

    localparam logic [CMD_WIDTH-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_READ = 2'd2;

endpackage
`default_nettype wire

// File: hdl/mts_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mts_in_if
// request channel: command and pushed word with valid/ready
// ----------------------------------------------------------------------------
interface mts_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                                 valid;
    logic                                 ready;
    logic        [mts_pkg::CMD_WIDTH-1:0] command;
    logic signed [DATA_WIDTH-1:0]         value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface
`default_nettype wire

// File: hdl/mts_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mts_out_if
// result channel: top, minimum, level and flags with valid/ready
// ----------------------------------------------------------------------------
interface mts_out_if #(
    parameter int DATA_WIDTH  = 32,
    parameter int LEVEL_WIDTH = 7
);
    logic                          valid;
    logic                          ready;
    logic signed [DATA_WIDTH-1:0]  top_value;
    logic signed [DATA_WIDTH-1:0]  min_value;
    logic        [LEVEL_WIDTH-1:0] fill_level;
    logic                          is_empty;
    logic                          push_rejected;
    logic                          pop_rejected;

    modport source (
        output valid, output top_value, output min_value, output fill_level,
        output is_empty, output push_rejected, output pop_rejected,
        input ready
    );
    modport sink (
        input valid, input top_value, input min_value, input fill_level,
        input is_empty, input push_rejected, input pop_rejected,
        output ready
    );
endinterface
`default_nettype wire

// File: hdl/mts_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mts_mem
// entry store below the top: one write port, one registered read port
// ----------------------------------------------------------------------------
module mts_mem #(
    parameter int DATA_WIDTH = 32,
    parameter int DEPTH      = 64,
    parameter int ADDR_WIDTH = 6
) (
    input  wire logic                    clk,
    input  wire logic                    wr_en,
    input  wire logic [ADDR_WIDTH-1:0]   wr_addr,
    input  wire logic [2*DATA_WIDTH-1:0] wr_data,
    input  wire logic                    rd_en,
    input  wire logic [ADDR_WIDTH-1:0]   rd_addr,
    output logic      [2*DATA_WIDTH-1:0] rd_data
);

    logic [2*DATA_WIDTH-1:0] store_mem [DEPTH];
    logic [2*DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: hdl/min_tracking_stack_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// min_tracking_stack_top
// lifo of signed words that reports its smallest held value on every request
// ----------------------------------------------------------------------------
// The stack takes one request at a time and returns exactly one result per
// request. The top entry and its running minimum live in registers; every
// entry below it sits in a single-port-write, registered-read memory together
// with the minimum that was current when it was pushed. A push, a read, a
// rejected request and a pop that empties the stack are done at the accepting
// edge: the result register loads at that edge and the next request can be
// taken in the following cycle, so back-to-back traffic runs at one request
// per cycle as long as the result side keeps taking results and no pop
// leaves entries behind. Such a pop passes through the load state, as the
// new top has to come back through the registered read port. The result
// register parts the two sides: a new request is accepted in the same cycle
// a waiting result is taken. Top and minimum read as 0 when the stack is
// empty; a push onto a full stack and a pop of an empty one change nothing
// and raise their flag. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module min_tracking_stack_top #(
    parameter int DATA_WIDTH = 32,
    parameter int DEPTH      = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    mts_in_if.sink    request,
    mts_out_if.source result
);

    localparam int ADDR_WIDTH  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LEVEL_WIDTH = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_LOAD
    } state_t;

    // control and top-of-stack registers
    state_t                        state_reg;
    logic        [LEVEL_WIDTH-1:0] fill_reg;
    logic signed [DATA_WIDTH-1:0]  top_reg;
    logic signed [DATA_WIDTH-1:0]  top_min_reg;

    // result register
    logic                          out_valid_reg;
    logic signed [DATA_WIDTH-1:0]  out_top_reg;
    logic signed [DATA_WIDTH-1:0]  out_min_reg;
    logic        [LEVEL_WIDTH-1:0] out_fill_reg;
    logic                          out_empty_reg;
    logic                          out_push_rej_reg;
    logic                          out_pop_rej_reg;

    logic                          accept;
    logic                          out_free;
    logic                          is_push;
    logic                          is_pop;
    logic                          stack_full;
    logic                          stack_empty;
    logic        [LEVEL_WIDTH-1:0] fill_m1;
    logic        [LEVEL_WIDTH-1:0] fill_m2;
    logic        [LEVEL_WIDTH-1:0] fill_p1;
    logic signed [DATA_WIDTH-1:0]  push_min;
    logic signed [DATA_WIDTH-1:0]  cur_top;
    logic signed [DATA_WIDTH-1:0]  cur_min;

    // memory port
    logic                          wr_en;
    logic        [ADDR_WIDTH-1:0]  wr_addr;
    logic        [2*DATA_WIDTH-1:0] wr_data;
    logic                          rd_en;
    logic        [ADDR_WIDTH-1:0]  rd_addr;
    logic        [2*DATA_WIDTH-1:0] rd_data;
    logic signed [DATA_WIDTH-1:0]  rd_value;
    logic signed [DATA_WIDTH-1:0]  rd_min;

    // result slot is free when empty or being taken this cycle
    assign out_free      = !out_valid_reg || result.ready;
    assign request.ready = (state_reg == S_IDLE) && out_free;
    assign accept        = request.valid && request.ready;

    assign is_push     = (request.command == mts_pkg::CMD_PUSH);
    assign is_pop      = (request.command == mts_pkg::CMD_POP);
    assign stack_full  = (fill_reg == LEVEL_WIDTH'(DEPTH));
    assign stack_empty = (fill_reg == '0);
    assign fill_m1     = fill_reg - LEVEL_WIDTH'(1);
    assign fill_m2     = fill_reg - LEVEL_WIDTH'(2);
    assign fill_p1     = fill_reg + LEVEL_WIDTH'(1);

    // running minimum for a new entry; a tie keeps the older minimum
    assign push_min = (!stack_empty && !(request.value < top_min_reg))
                    ? top_min_reg : request.value;

    // top and minimum as seen by the outside, zero when empty
    assign cur_top = stack_empty ? '0 : top_reg;
    assign cur_min = stack_empty ? '0 : top_min_reg;

    // a push spills the old top into the memory below the new one
    assign wr_en   = accept && is_push && !stack_full && !stack_empty;
    assign wr_addr = fill_m1[ADDR_WIDTH-1:0];
    assign wr_data = {top_reg, top_min_reg};

    // a pop that leaves entries fetches the entry under the top
    assign rd_en   = accept && is_pop && (fill_reg > LEVEL_WIDTH'(1));
    assign rd_addr = fill_m2[ADDR_WIDTH-1:0];

    assign rd_value = rd_data[2*DATA_WIDTH-1:DATA_WIDTH];
    assign rd_min   = rd_data[DATA_WIDTH-1:0];

    mts_mem #(
        .DATA_WIDTH (DATA_WIDTH),
        .DEPTH      (DEPTH),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            fill_reg         <= '0;
            top_reg          <= '0;
            top_min_reg      <= '0;
            out_valid_reg    <= 1'b0;
            out_top_reg      <= '0;
            out_min_reg      <= '0;
            out_fill_reg     <= '0;
            out_empty_reg    <= 1'b1;
            out_push_rej_reg <= 1'b0;
            out_pop_rej_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        out_valid_reg    <= 1'b1;
                        out_push_rej_reg <= 1'b0;
                        out_pop_rej_reg  <= 1'b0;
                        out_top_reg      <= cur_top;
                        out_min_reg      <= cur_min;
                        out_fill_reg     <= fill_reg;
                        out_empty_reg    <= stack_empty;
                        if (is_push)
                        begin
                            if (stack_full)
                            begin
                                out_push_rej_reg <= 1'b1;
                            end
                            else
                            begin
                                top_reg       <= request.value;
                                top_min_reg   <= push_min;
                                fill_reg      <= fill_p1;
                                out_top_reg   <= request.value;
                                out_min_reg   <= push_min;
                                out_fill_reg  <= fill_p1;
                                out_empty_reg <= 1'b0;
                            end
                        end
                        else if (is_pop)
                        begin
                            if (stack_empty)
                            begin
                                out_pop_rej_reg <= 1'b1;
                            end
                            else if (fill_reg == LEVEL_WIDTH'(1))
                            begin
                                fill_reg      <= '0;
                                out_top_reg   <= '0;
                                out_min_reg   <= '0;
                                out_fill_reg  <= '0;
                                out_empty_reg <= 1'b1;
                            end
                            else
                            begin
                                // new top arrives from memory next cycle
                                fill_reg      <= fill_m1;
                                out_valid_reg <= 1'b0;
                                state_reg     <= S_LOAD;
                            end
                        end
                    end
                end
                S_LOAD:
                begin
                    top_reg          <= rd_value;
                    top_min_reg      <= rd_min;
                    out_valid_reg    <= 1'b1;
                    out_top_reg      <= rd_value;
                    out_min_reg      <= rd_min;
                    out_fill_reg     <= fill_reg;
                    out_empty_reg    <= 1'b0;
                    out_push_rej_reg <= 1'b0;
                    out_pop_rej_reg  <= 1'b0;
                    state_reg        <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.top_value     = out_top_reg;
    assign result.min_value     = out_min_reg;
    assign result.fill_level    = out_fill_reg;
    assign result.is_empty      = out_empty_reg;
    assign result.push_rejected = out_push_rej_reg;
    assign result.pop_rejected  = out_pop_rej_reg;

    // level never passes the capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= LEVEL_WIDTH'(DEPTH))
        else $error("fill level above capacity");

    // memory is never written and read in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("memory write and read overlap");

    // the load cycle always finds the result slot empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> !out_valid_reg)
        else $error("result slot busy during load");

    // a pop that leaves entries goes through the load cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> (state_reg == S_LOAD) && !request.ready)
        else $error("pop did not wait for memory data");

    // an accepted push on a non-full stack raises the level by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_push && !stack_full) |=> (fill_reg == $past(fill_p1)))
        else $error("push did not raise the level");

endmodule
`default_nettype wire
